/* rtl/core/ubsc_pkg.sv */
// Package for the upper-bound supersolution check core.
// Holds the transaction structs, status codes and shared constants.
// No dependencies.
package ubsc_pkg;

  localparam int DEFAULT_MAX_COMPONENTS = 65536;
  localparam int DEFAULT_MID_DEPTH      = 4;
  localparam int DEFAULT_OUT_DEPTH      = 2;

  localparam logic [63:0] POS_INF_BITS = 64'h7FF0_0000_0000_0000;

  // Report status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_INPUT_FAIL = 2'd1;
  localparam logic [1:0] STATUS_OP_NEG     = 2'd2;
  localparam logic [1:0] STATUS_NOT_SUPER  = 2'd3;

  // One vector component
  typedef struct packed {
    logic [63:0] residual_bound;
    logic [63:0] candidate_value;
    logic [63:0] operator_value;
    logic        last_component;
  } in_item_t;

  // One report
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] bad_index;
    logic [63:0] reported_candidate;
    logic [63:0] reported_required;
    logic [63:0] smallest_margin;
  } out_item_t;

  // Classified component with its rounded-up sum, front to back
  typedef struct packed {
    logic [63:0] residual_bound;
    logic [63:0] candidate_value;
    logic [63:0] operator_value;
    logic        last_component;
    logic        in_fail;
    logic        op_inf;
    logic        op_neg;
    logic        sum_ovf;
    logic [63:0] sum_bits;
  } mid_item_t;

endpackage

/* rtl/core/ubsc_fifo.sv */
// Small flop-based queue used between the front and back and on the result side.
// Generic in width and depth; no package dependency.
module ubsc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

/* rtl/core/ubsc_front.sv */
// Front end: accepts components, classifies the inputs and forms the
// rounded-up sum residual + operator in four stages. Uses ubsc_pkg.
module ubsc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ubsc_pkg::in_item_t   item,
  output logic                 full,
  output logic                 mid_push,
  output ubsc_pkg::mid_item_t  mid_item,
  input  logic                 mid_full
);

  typedef struct packed {
    logic in_fail;
    logic op_inf;
    logic op_neg;
    logic zsign;
  } fe_flags_t;

  function automatic logic nonfinite(input logic [63:0] x);
    return &x[62:52];
  endfunction

  function automatic logic neg_nonzero(input logic [63:0] x);
    return x[63] & (|x[62:0]);
  endfunction

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  ubsc_pkg::in_item_t s1_item, s2_item, s3_item;
  fe_flags_t          s1_flags, s2_flags, s3_flags;
  logic [62:0]        s1_big, s1_small;
  logic [52:0]        s2_big_m;
  logic [10:0]        s2_big_e, s3_big_e;
  logic [54:0]        s2_small_al;
  logic               s2_sticky, s3_sticky;
  logic [55:0]        s3_sum;
  ubsc_pkg::mid_item_t s4;

  // Stage 1 logic: classify and order the two addends
  fe_flags_t   c1_flags;
  logic [62:0] c1_big, c1_small;
  logic        c1_swap;

  always_comb begin
    c1_flags.in_fail = nonfinite(item.residual_bound) | neg_nonzero(item.residual_bound) |
                       nonfinite(item.candidate_value) | neg_nonzero(item.candidate_value);
    c1_flags.op_inf  = nonfinite(item.operator_value);
    c1_flags.op_neg  = neg_nonzero(item.operator_value);
    c1_flags.zsign   = item.residual_bound[63] & item.operator_value[63];
    c1_swap  = item.operator_value[62:0] > item.residual_bound[62:0];
    c1_big   = c1_swap ? item.operator_value[62:0] : item.residual_bound[62:0];
    c1_small = c1_swap ? item.residual_bound[62:0] : item.operator_value[62:0];
  end

  // Stage 2 logic: align the smaller significand, keep a sticky bit
  logic [10:0]  c2_be, c2_se, c2_d;
  logic [5:0]   c2_shamt;
  logic [52:0]  c2_small_m;
  logic [118:0] c2_wide;

  always_comb begin
    c2_be      = (s1_big[62:52] == 11'd0) ? 11'd1 : s1_big[62:52];
    c2_se      = (s1_small[62:52] == 11'd0) ? 11'd1 : s1_small[62:52];
    c2_d       = c2_be - c2_se;
    c2_shamt   = (c2_d > 11'd63) ? 6'd63 : c2_d[5:0];
    c2_small_m = {|s1_small[62:52], s1_small[51:0]};
    c2_wide    = {c2_small_m, 2'b00, 64'd0} >> c2_shamt;
  end

  // Stage 3 logic: significand add
  logic [55:0] c3_sum;
  assign c3_sum = {1'b0, s2_big_m, 2'b00} + {1'b0, s2_small_al};

  // Stage 4 logic: pack and round towards +infinity
  logic        c4_carry, c4_inexact;
  logic [52:0] c4_mant;
  logic [11:0] c4_base;
  logic [63:0] c4_packed;

  always_comb begin
    c4_carry   = s3_sum[55];
    c4_mant    = c4_carry ? s3_sum[55:3] : s3_sum[54:2];
    c4_inexact = s3_sticky | (c4_carry ? (|s3_sum[2:0]) : (|s3_sum[1:0]));
    c4_base    = c4_carry ? {1'b0, s3_big_e} : ({1'b0, s3_big_e} - 12'd1);
    c4_packed  = {c4_base, 52'd0} + {11'd0, c4_mant} + {63'd0, c4_inexact};
  end

  // Elastic stage control
  assign rdy4     = !v4 || !mid_full;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign full     = !rdy1;
  assign mid_push = v4;
  assign mid_item = s4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= push;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_item  <= item;
      s1_flags <= c1_flags;
      s1_big   <= c1_big;
      s1_small <= c1_small;
    end
    if (rdy2) begin
      s2_item     <= s1_item;
      s2_flags    <= s1_flags;
      s2_big_m    <= {|s1_big[62:52], s1_big[51:0]};
      s2_big_e    <= c2_be;
      s2_small_al <= c2_wide[118:64];
      s2_sticky   <= |c2_wide[63:0];
    end
    if (rdy3) begin
      s3_item   <= s2_item;
      s3_flags  <= s2_flags;
      s3_sum    <= c3_sum;
      s3_big_e  <= s2_big_e;
      s3_sticky <= s2_sticky;
    end
    if (rdy4) begin
      s4.residual_bound  <= s3_item.residual_bound;
      s4.candidate_value <= s3_item.candidate_value;
      s4.operator_value  <= s3_item.operator_value;
      s4.last_component  <= s3_item.last_component;
      s4.in_fail         <= s3_flags.in_fail;
      s4.op_inf          <= s3_flags.op_inf;
      s4.op_neg          <= s3_flags.op_neg;
      s4.sum_ovf         <= (c4_packed[63:52] >= 12'h7FF);
      s4.sum_bits        <= {s3_flags.zsign, c4_packed[62:0]};
    end
  end

endmodule

/* rtl/core/ubsc_back.sv */
// Back end: margin candidate - sum in round-to-nearest over six stages, then
// running minimum, first-failure records and the per-vector report. Uses ubsc_pkg.
module ubsc_back #(
  parameter int MAX_COMPONENTS = ubsc_pkg::DEFAULT_MAX_COMPONENTS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                mid_empty,
  input  ubsc_pkg::mid_item_t mid_item,
  output logic                mid_pop,
  input  logic                out_full,
  output logic                out_push,
  output ubsc_pkg::out_item_t out_item
);

  localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int IW = (CW > 16) ? CW : 16;

  typedef struct packed {
    logic m_sign;
    logic c_fail;
  } bk_tag_t;

  function automatic logic fp_less(input logic [63:0] a, input logic [63:0] b);
    logic res;
    if (!(|a[62:0]) && !(|b[62:0])) begin
      res = 1'b0;
    end else begin
      unique case ({a[63], b[63]})
        2'b10:   res = 1'b1;
        2'b01:   res = 1'b0;
        2'b00:   res = a[62:0] < b[62:0];
        default: res = a[62:0] > b[62:0];
      endcase
    end
    return res;
  endfunction

  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, acc_rdy, consume;

  ubsc_pkg::mid_item_t b1_item, b2_item, b3_item, b4_item, b5_item, b6_item;
  bk_tag_t             b1_tag, b2_tag, b3_tag, b4_tag, b5_tag, b6_tag;
  logic [62:0] b1_big, b1_small;
  logic [55:0] b2_a, b2_b, b3_d, b4_d, b5_n;
  logic [10:0] b2_ex, b3_ex, b4_ex, b5_en;
  logic [5:0]  b4_sh;
  logic [63:0] b6_m;

  // Stage 1 logic: order the magnitudes, settle the sign of the margin
  bk_tag_t     c1_tag;
  logic [62:0] c1_mc, c1_ms;
  logic        c1_eq;

  always_comb begin
    c1_mc         = mid_item.candidate_value[62:0];
    c1_ms         = mid_item.sum_bits[62:0];
    c1_eq         = (c1_mc == c1_ms);
    c1_tag.c_fail = c1_mc < c1_ms;
    c1_tag.m_sign = c1_eq ? (!(|c1_mc) & mid_item.candidate_value[63] & ~mid_item.sum_bits[63])
                          : c1_tag.c_fail;
  end

  // Stage 2 logic: align with guard, round and sticky
  logic [10:0]  c2_ex, c2_ey, c2_d;
  logic [5:0]   c2_shamt;
  logic [119:0] c2_wide;

  always_comb begin
    c2_ex    = (b1_big[62:52] == 11'd0) ? 11'd1 : b1_big[62:52];
    c2_ey    = (b1_small[62:52] == 11'd0) ? 11'd1 : b1_small[62:52];
    c2_d     = c2_ex - c2_ey;
    c2_shamt = (c2_d > 11'd63) ? 6'd63 : c2_d[5:0];
    c2_wide  = {|b1_small[62:52], b1_small[51:0], 3'b000, 64'd0} >> c2_shamt;
  end

  // Stage 3 logic: magnitude subtract
  logic [55:0] c3_d;
  assign c3_d = b2_a - b2_b;

  // Stage 4 logic: leading-zero count, limited by the subnormal floor
  logic [5:0]  c4_lz, c4_sh;
  logic [10:0] c4_lim;

  always_comb begin
    c4_lz = 6'd56;
    for (int i = 0; i < 56; i++) begin
      if (b3_d[i]) c4_lz = 6'(55 - i);
    end
    c4_lim = b3_ex - 11'd1;
    c4_sh  = ({5'd0, c4_lz} < c4_lim) ? c4_lz : c4_lim[5:0];
  end

  // Stage 6 logic: round to nearest even and pack; exact cancellation gives zero
  logic [52:0] c6_mant;
  logic        c6_up;
  logic [62:0] c6_packed;

  always_comb begin
    c6_mant = b5_n[55:3];
    c6_up   = b5_n[2] & ((|b5_n[1:0]) | c6_mant[0]);
    if (b5_n == '0) begin
      c6_packed = 63'd0;
    end else begin
      c6_packed = {b5_en - 11'd1, 52'd0} + {10'd0, c6_mant} + {62'd0, c6_up};
    end
  end

  // Elastic stage control
  assign acc_rdy = !(b6_item.last_component && out_full);
  assign consume = v6 && acc_rdy;
  assign rdy6    = !v6 || acc_rdy;
  assign rdy5    = !v5 || rdy6;
  assign rdy4    = !v4 || rdy5;
  assign rdy3    = !v3 || rdy4;
  assign rdy2    = !v2 || rdy3;
  assign rdy1    = !v1 || rdy2;
  assign mid_pop = !mid_empty && rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (rdy1) v1 <= !mid_empty;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (rdy1) begin
      b1_item  <= mid_item;
      b1_tag   <= c1_tag;
      b1_big   <= c1_tag.c_fail ? c1_ms : c1_mc;
      b1_small <= c1_tag.c_fail ? c1_mc : c1_ms;
    end
    if (rdy2) begin
      b2_item <= b1_item;
      b2_tag  <= b1_tag;
      b2_a    <= {|b1_big[62:52], b1_big[51:0], 3'b000};
      b2_b    <= c2_wide[119:64] | {55'd0, |c2_wide[63:0]};
      b2_ex   <= c2_ex;
    end
    if (rdy3) begin
      b3_item <= b2_item;
      b3_tag  <= b2_tag;
      b3_d    <= c3_d;
      b3_ex   <= b2_ex;
    end
    if (rdy4) begin
      b4_item <= b3_item;
      b4_tag  <= b3_tag;
      b4_d    <= b3_d;
      b4_ex   <= b3_ex;
      b4_sh   <= c4_sh;
    end
    if (rdy5) begin
      b5_item <= b4_item;
      b5_tag  <= b4_tag;
      b5_n    <= b4_d << b4_sh;
      b5_en   <= b4_ex - 11'(b4_sh);
    end
    if (rdy6) begin
      b6_item <= b5_item;
      b6_tag  <= b5_tag;
      b6_m    <= {b5_tag.m_sign, c6_packed};
    end
  end

  // Vector records
  logic [CW-1:0] count;
  logic          if_seen, cf_seen;
  logic [15:0]   if_index, cf_index;
  logic [63:0]   if_cand, if_res;
  logic [1:0]    cf_code;
  logic [63:0]   cf_cand, cf_req, cf_margin, run_margin;

  logic [IW-1:0] count_w;
  logic [15:0]   idx16;
  logic          if_now, if_seen_n, check_on, sum_ok, cf_now;
  logic [1:0]    code;
  logic [63:0]   rm_new, req;

  always_comb begin
    count_w   = IW'(count);
    idx16     = count_w[15:0];
    if_now    = !if_seen && b6_item.in_fail;
    if_seen_n = if_seen || b6_item.in_fail;
    check_on  = !if_seen_n && !cf_seen;
    sum_ok    = !b6_item.op_inf && !b6_item.op_neg && !b6_item.sum_ovf;
    priority if (b6_item.op_inf)  code = ubsc_pkg::STATUS_INPUT_FAIL;
    else if (b6_item.op_neg)      code = ubsc_pkg::STATUS_OP_NEG;
    else if (b6_item.sum_ovf)     code = ubsc_pkg::STATUS_INPUT_FAIL;
    else if (b6_tag.c_fail)       code = ubsc_pkg::STATUS_NOT_SUPER;
    else                          code = ubsc_pkg::STATUS_OK;
    rm_new = (check_on && sum_ok && fp_less(b6_m, run_margin)) ? b6_m : run_margin;
    req    = (code == ubsc_pkg::STATUS_NOT_SUPER) ? b6_item.sum_bits : b6_item.operator_value;
    cf_now = check_on && (code != ubsc_pkg::STATUS_OK);
  end

  // Report from the records as they stand after this component
  always_comb begin
    priority if (if_seen_n) begin
      out_item.status             = ubsc_pkg::STATUS_INPUT_FAIL;
      out_item.bad_index          = if_now ? idx16 : if_index;
      out_item.reported_candidate = if_now ? b6_item.candidate_value : if_cand;
      out_item.reported_required  = if_now ? b6_item.residual_bound : if_res;
      out_item.smallest_margin    = ubsc_pkg::POS_INF_BITS;
    end else if (cf_seen || cf_now) begin
      out_item.status             = cf_now ? code : cf_code;
      out_item.bad_index          = cf_now ? idx16 : cf_index;
      out_item.reported_candidate = cf_now ? b6_item.candidate_value : cf_cand;
      out_item.reported_required  = cf_now ? req : cf_req;
      out_item.smallest_margin    = cf_now ? rm_new : cf_margin;
    end else begin
      out_item.status             = ubsc_pkg::STATUS_OK;
      out_item.bad_index          = 16'd0;
      out_item.reported_candidate = 64'd0;
      out_item.reported_required  = 64'd0;
      out_item.smallest_margin    = rm_new;
    end
  end

  assign out_push = consume && b6_item.last_component;

  // Control part of the records
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      if_seen    <= 1'b0;
      cf_seen    <= 1'b0;
      run_margin <= ubsc_pkg::POS_INF_BITS;
    end else if (consume) begin
      if (b6_item.last_component) begin
        count      <= '0;
        if_seen    <= 1'b0;
        cf_seen    <= 1'b0;
        run_margin <= ubsc_pkg::POS_INF_BITS;
      end else begin
        count      <= (count == CW'(MAX_COMPONENTS - 1)) ? '0 : count + CW'(1);
        if_seen    <= if_seen_n;
        cf_seen    <= cf_seen || cf_now;
        run_margin <= rm_new;
      end
    end
  end

  // Payload part of the records, qualified by the seen flags
  always_ff @(posedge clk) begin
    if (consume && if_now) begin
      if_index <= idx16;
      if_cand  <= b6_item.candidate_value;
      if_res   <= b6_item.residual_bound;
    end
    if (consume && cf_now) begin
      cf_code   <= code;
      cf_index  <= idx16;
      cf_cand   <= b6_item.candidate_value;
      cf_req    <= req;
      cf_margin <= rm_new;
    end
  end

endmodule

/* rtl/core/upper_bound_supersolution_check_core.sv */
// Upper-bound supersolution check core: one component per unstalled clock, one report per vector.
// Throughput: one component per cycle, set by the 4-stage sum and 6-stage margin pipelines,
// while no full middle or result queue stalls them.
// Reset: rst is synchronous, active high; it empties both queues and clears the vector records.
// Top level; depends on ubsc_pkg, ubsc_front, ubsc_fifo and ubsc_back.
module upper_bound_supersolution_check_core #(
  parameter int MAX_COMPONENTS = ubsc_pkg::DEFAULT_MAX_COMPONENTS,
  parameter int MID_DEPTH      = ubsc_pkg::DEFAULT_MID_DEPTH,
  parameter int OUT_DEPTH      = ubsc_pkg::DEFAULT_OUT_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  ubsc_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output ubsc_pkg::out_item_t result
);

  localparam int MID_W = $bits(ubsc_pkg::mid_item_t);
  localparam int OUT_W = $bits(ubsc_pkg::out_item_t);

  logic                mid_push, mid_full, mid_empty, mid_pop;
  ubsc_pkg::mid_item_t mid_in, mid_out;
  logic                out_push, out_full;
  ubsc_pkg::out_item_t out_in;

  // Classification and rounded-up sum
  ubsc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .mid_push (mid_push),
    .mid_item (mid_in),
    .mid_full (mid_full)
  );

  // Decoupling queue between front and back
  ubsc_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_out),
    .empty (mid_empty)
  );

  // Margin, records and report
  ubsc_back #(
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_item  (mid_out),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_item  (out_in)
  );

  // Report queue
  ubsc_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_in),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

`ifndef SYNTHESIS
  a_out_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("report pushed into a full result queue");

  a_front_holds: assert property (@(posedge clk) disable iff (rst)
    (mid_push && mid_full) |=> mid_push)
    else $error("front dropped a stalled transaction");

  a_ok_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ubsc_pkg::STATUS_OK) |->
      (result.bad_index == 16'd0 && result.reported_candidate == 64'd0))
    else $error("ok report carries failure fields");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result queue not empty after reset");
`endif

endmodule

/* verif/ubsc_scoreboard.sv */
// Checker for the upper-bound supersolution check core: watches both queue ports,
// predicts each vector report from the accepted components and compares them.
// Depends on ubsc_pkg for the transaction structs and status codes.
`timescale 1ns / 1ps

module ubsc_scoreboard
  import ubsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  in_item_t  item,
  input  logic      empty,
  input  logic      pop,
  input  out_item_t result,
  output int        errors,
  output int        pending,
  output int        reports,
  output int        components
);

  // Per-vector records
  logic [15:0] comp_idx;
  logic        in_bad;
  logic [15:0] in_bad_idx;
  logic [63:0] in_bad_cand;
  logic [63:0] in_bad_res;
  logic        chk_bad;
  logic [1:0]  chk_code;
  logic [15:0] chk_idx;
  logic [63:0] chk_cand;
  logic [63:0] chk_req;
  logic [63:0] chk_margin;
  logic [63:0] min_margin;

  out_item_t expected_reports[$];

  function automatic logic is_fin(logic [63:0] b);
    return b[62:52] != 11'h7FF;
  endfunction

  // Finite and >= 0.0; negative zero passes
  function automatic logic is_nonneg(logic [63:0] b);
    return is_fin(b) && (!b[63] || b[62:0] == '0);
  endfunction

  // Sum rounded towards +inf via two-sum; returns 0 on overflow or invalid input
  function automatic logic sum_round_up(logic [63:0] ab, logic [63:0] bb,
                                        output logic [63:0] sb);
    real a, b, s, bv, err;
    a  = $bitstoreal(ab);
    b  = $bitstoreal(bb);
    sb = '0;
    if (!is_nonneg(ab) || !is_nonneg(bb)) return 1'b0;
    s  = a + b;
    sb = $realtobits(s);
    if (!is_fin(sb)) return 1'b0;
    bv  = s - a;
    err = (a - (s - bv)) + (b - bv);
    if (err > 0.0) sb = sb + 64'd1;
    return is_fin(sb);
  endfunction

  task automatic clear_records();
    comp_idx    = '0;
    in_bad      = 1'b0;
    in_bad_idx  = '0;
    in_bad_cand = '0;
    in_bad_res  = '0;
    chk_bad     = 1'b0;
    chk_code    = STATUS_OK;
    chk_idx     = '0;
    chk_cand    = '0;
    chk_req     = '0;
    chk_margin  = POS_INF_BITS;
    min_margin  = POS_INF_BITS;
  endtask

  // Fold one component into the records; queue a report on the last one
  task automatic predict_component(in_item_t it);
    logic [1:0]  code;
    logic [63:0] req;
    logic [63:0] sb;
    real         m;
    out_item_t   rep;
    if (!in_bad && (!is_nonneg(it.residual_bound) || !is_nonneg(it.candidate_value))) begin
      in_bad      = 1'b1;
      in_bad_idx  = comp_idx;
      in_bad_cand = it.candidate_value;
      in_bad_res  = it.residual_bound;
    end
    if (!in_bad && !chk_bad) begin
      code = STATUS_OK;
      req  = it.operator_value;
      if (!is_fin(it.operator_value)) begin
        code = STATUS_INPUT_FAIL;
      end else if ($bitstoreal(it.operator_value) < 0.0) begin
        code = STATUS_OP_NEG;
      end else if (!sum_round_up(it.residual_bound, it.operator_value, sb)) begin
        code = STATUS_INPUT_FAIL;
      end else begin
        m = $bitstoreal(it.candidate_value) - $bitstoreal(sb);
        if (m < $bitstoreal(min_margin)) min_margin = $realtobits(m);
        if (!($bitstoreal(it.candidate_value) >= $bitstoreal(sb))) begin
          code = STATUS_NOT_SUPER;
          req  = sb;
        end
      end
      if (code != STATUS_OK) begin
        chk_bad    = 1'b1;
        chk_code   = code;
        chk_idx    = comp_idx;
        chk_cand   = it.candidate_value;
        chk_req    = req;
        chk_margin = min_margin;
      end
    end
    comp_idx = comp_idx + 16'd1;
    if (it.last_component) begin
      if (in_bad) begin
        rep = '{STATUS_INPUT_FAIL, in_bad_idx, in_bad_cand, in_bad_res, POS_INF_BITS};
      end else if (chk_bad) begin
        rep = '{chk_code, chk_idx, chk_cand, chk_req, chk_margin};
      end else begin
        rep = '{STATUS_OK, 16'd0, 64'd0, 64'd0, min_margin};
      end
      expected_reports.push_back(rep);
      clear_records();
    end
  endtask

  task automatic check_report(out_item_t got);
    out_item_t exp;
    if (expected_reports.size() == 0) begin
      errors++;
      $display("%0t: unexpected report %h", $time, got);
      return;
    end
    exp = expected_reports.pop_front();
    reports++;
    if (got.status != exp.status)
      $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
    if (got.bad_index != exp.bad_index)
      $display("%0t: bad_index exp %0d got %0d", $time, exp.bad_index, got.bad_index);
    if (got.reported_candidate != exp.reported_candidate)
      $display("%0t: reported_candidate exp %h got %h", $time,
               exp.reported_candidate, got.reported_candidate);
    if (got.reported_required != exp.reported_required)
      $display("%0t: reported_required exp %h got %h", $time,
               exp.reported_required, got.reported_required);
    if (got.smallest_margin != exp.smallest_margin)
      $display("%0t: smallest_margin exp %h got %h", $time,
               exp.smallest_margin, got.smallest_margin);
    if (got != exp) errors++;
  endtask

  initial begin
    errors     = 0;
    pending    = 0;
    reports    = 0;
    components = 0;
    clear_records();
  end

  // Sample both channels at the edge that completes each transaction
  always @(posedge clk) begin
    if (rst) begin
      expected_reports.delete();
      clear_records();
    end else begin
      if (pop && !empty) check_report(result);
      if (push && !full) begin
        components++;
        predict_component(item);
      end
    end
    pending = expected_reports.size();
  end

endmodule

/* verif/testbench.sv */
// Top of the upper-bound supersolution check testbench: clock, reset, stimulus
// and verdict. Depends on ubsc_pkg, the core and ubsc_scoreboard.
`timescale 1ns / 1ps

module testbench;
  import ubsc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 30;

  localparam logic [63:0] F_ONE   = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] F_TWO   = 64'h4000_0000_0000_0000;
  localparam logic [63:0] F_THREE = 64'h4008_0000_0000_0000;
  localparam logic [63:0] F_FIVE  = 64'h4014_0000_0000_0000;
  localparam logic [63:0] F_TINY  = 64'h3C30_0000_0000_0000; // 2^-60
  localparam logic [63:0] F_MAX   = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] F_NZERO = 64'h8000_0000_0000_0000;
  localparam logic [63:0] F_NINF  = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] F_NAN   = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] F_MONE  = 64'hBFF0_0000_0000_0000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full, empty;
  in_item_t  item = '0;
  out_item_t result;

  int errors, pending, reports, components;
  int gap_pct   = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  upper_bound_supersolution_check_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  ubsc_scoreboard checker_i (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result), .errors(errors),
    .pending(pending), .reports(reports), .components(components)
  );

  // Receiver: random back-pressure
  always @(posedge clk) pop <= ($urandom_range(99) >= stall_pct);

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // One component; push stays high across back-to-back transactions
  task automatic put(logic [63:0] r, logic [63:0] c, logic [63:0] o, logic last);
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= '{r, c, o, last};
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Let the checker see the last transaction before looking at its count
  task automatic idle_until_drained();
    push <= 1'b0;
    @(posedge clk);
    #0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Anything at all: zeros, infinities, NaNs, negatives, subnormals, huge, raw bits
  function automatic logic [63:0] odd_double();
    case ($urandom_range(9))
      0: return '0;
      1: return F_NZERO;
      2: return POS_INF_BITS;
      3: return {1'($urandom_range(1)), 11'h7FF, 20'($urandom) | 20'd1, 32'($urandom)};
      4: return F_NINF;
      5: return {1'b1, 11'($urandom_range(2046)), 20'($urandom), 32'($urandom)};
      6: return {12'h000, 20'($urandom), 32'($urandom)};
      7: return {1'b0, 11'h7FE, 20'($urandom), 32'($urandom)};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Positive moderate value with a random mantissa
  function automatic logic [63:0] plain_double();
    return {1'b0, 11'($urandom_range(1000, 1046)), 20'($urandom), 32'($urandom)};
  endfunction

  // Mostly well-formed vectors, candidates from 3 ulps below to 37 above the sum
  task automatic random_vector(int len);
    logic [63:0] r, c, o;
    for (int i = 0; i < len; i++) begin
      r = plain_double();
      o = ($urandom_range(9) == 0) ? 64'd0 : plain_double();
      c = $realtobits($bitstoreal(r) + $bitstoreal(o))
          + 64'($signed($urandom_range(40)) - 3);
      if ($urandom_range(99) < 4) r = odd_double();
      if ($urandom_range(99) < 4) c = odd_double();
      if ($urandom_range(99) < 5) o = odd_double();
      put(r, c, o, i == len - 1);
    end
  endtask

  task automatic random_phase(int gap, int stall, int n_items);
    int sent, len;
    gap_pct   = gap;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      random_vector(len);
      sent += len;
    end
    idle_until_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: corner values of each outcome
    put(F_ONE, F_THREE, F_TWO, 1'b1);                 // exact, zero margin
    put(F_ONE, F_ONE, F_TINY, 1'b1);                  // inexact sum rounds up past candidate
    put('0, '0, F_NZERO, 1'b0);                       // zeros of both signs
    put(F_MAX, F_MAX, '0, 1'b1);
    put(F_ONE, F_NAN, F_ONE, 1'b1);                   // candidate NaN
    put(F_MONE, F_FIVE, F_ONE, 1'b1);                 // residual negative
    put(F_ONE, F_FIVE, POS_INF_BITS, 1'b1);           // operator infinite
    put(F_ONE, F_FIVE, F_MONE, 1'b1);                 // operator negative
    put(F_MAX, F_MAX, F_MAX, 1'b1);                   // sum overflows
    put(F_MAX, F_MAX, F_ONE, 1'b1);                   // rounding up overflows
    put(F_ONE, F_FIVE, F_MONE, 1'b0);                 // input failure outranks operator
    put(F_ONE, F_NINF, F_ONE, 1'b1);
    put(F_ONE, {1'b0, 63'h7FEF_FFFF_FFFF_FFFF}, F_ONE, 1'b0);
    put(F_ONE, F_FIVE, F_TWO, 1'b0);                  // margin tracked, then failure
    put(F_TWO, F_ONE, F_TWO, 1'b1);
    put(F_ONE, F_ONE, 64'd1, 1'b1);                   // subnormal operator
    idle_until_drained();

    // Longer vector: margin tracked over many components, failure near the end
    for (int i = 0; i < 24; i++)
      put(F_ONE, (i == 19) ? F_ONE : F_THREE, F_ONE, i == 23);
    idle_until_drained();

    random_phase(0, 0, 150);
    random_phase(77, 0, 150);
    random_phase(0, 77, 150);
    random_phase(10, 10, 150);

    $display("Checked %0d reports over %0d components (directed corners, a longer",
             reports, components);
    $display("vector, random vectors under four idle/stall mixes).");
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
